// ===== sv/length_prefixed_record_fifo_core_assert.svh =====
// Assertion macros for the length-prefixed record FIFO core.
// Included by the top level; no other dependencies.
`ifndef LENGTH_PREFIXED_RECORD_FIFO_CORE_ASSERT_SVH
`define LENGTH_PREFIXED_RECORD_FIFO_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked assertion, disabled while reset is asserted
`define LPRF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked assertion that is also checked during reset
`define LPRF_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPRF_ASSERT(lbl, clk, rstn, prop, msg)
`define LPRF_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== sv/lprf_pkg.sv =====
// Shared types and constants of the length-prefixed record FIFO core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lprf_pkg;

  localparam int DEFAULT_BUFFER_BYTES = 1024;
  localparam int MAX_RECORD           = 255;
  localparam int HELD_BITS            = 10;
  localparam int FREE_BITS            = 11;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_POP   = 2'd2;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD_LEN = 3'd1,
    ST_NO_ROOM = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_SEQ     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_START,
    OP_WRITE,
    OP_POP,
    OP_ILLEGAL
  } op_e;

  typedef enum logic {
    BK_IDLE,
    BK_POP
  } back_state_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] record_length;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [7:0]           read_byte;
    logic                 last_byte;
    logic [HELD_BITS-1:0] records_held;
    logic [FREE_BITS-1:0] free_bytes;
  } out_item_t;

  // Classified transaction as held in the queue between front and back
  typedef struct packed {
    op_e        op;
    logic       len_bad;
    logic [7:0] record_length;
    logic [7:0] data_byte;
  } entry_t;

endpackage

// ===== sv/length_prefixed_record_fifo_core.sv =====
// Length-prefixed record FIFO: ring buffer of byte records with length headers.
// Top level; uses lprf_pkg, lprf_front, lprf_back and the assertion header.
//
// Usage:
//   One input transaction per request: start a record (action 0, length
//   1..255), write one data byte (action 1) or pop one byte (action 2).
//   Every transaction yields exactly one result transaction, in order, with
//   a status, the popped byte and its last mark, and the record and free
//   byte counts after the step.
//   A start or write result passes the queue register and the result
//   register; a pop result also passes the registered read of the store.
//   Throughput: one start or write per cycle while results are not stalled;
//   a pop waits in the pop state for the registered read of the byte store,
//   and the back end takes no new transaction until the pop result is loaded.
//   A two-entry queue parts the front end from the back end; in_stall_o
//   rises when it is full.
//   Reset: pointers and counts clear, all BUFFER_BYTES are free; the store
//   is not cleared, as no entry is read before it has been written.
//   Receiver stall: the result register holds, the back end stops, the
//   queue fills and then the input side is stalled.
`timescale 1ns / 1ps
`include "length_prefixed_record_fifo_core_assert.svh"

module length_prefixed_record_fifo_core #(
  parameter int BUFFER_BYTES = lprf_pkg::DEFAULT_BUFFER_BYTES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lprf_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lprf_pkg::out_item_t out_data_o
);
  import lprf_pkg::*;

  logic   q_valid;
  logic   q_take;
  entry_t q_entry;

  lprf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_entry_o  (q_entry),
    .q_take_i   (q_take)
  );

  lprf_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_take_o    (q_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `LPRF_ASSERT(a_take_needs_entry, clk_i, rst_ni, q_take |-> q_valid, "take from empty queue")
  `LPRF_ASSERT(a_fail_no_byte, clk_i, rst_ni, (out_valid_o && out_data_o.status != ST_OK) |-> (out_data_o.read_byte == 8'd0 && !out_data_o.last_byte), "failed step carries data")
  `LPRF_ASSERT(a_held_bound, clk_i, rst_ni, out_valid_o |-> (32'(out_data_o.records_held) <= BUFFER_BYTES / 2), "record count beyond capacity")
  `LPRF_ASSERT(a_free_bound, clk_i, rst_ni, out_valid_o |-> (32'(out_data_o.free_bytes) <= BUFFER_BYTES), "free count beyond capacity")
  `LPRF_ASSERT_NR(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o, "result valid during reset")

endmodule

// ===== sv/lprf_front.sv =====
// Front end: accepts input transactions, decodes them and queues them.
// Depends on lprf_pkg.
`timescale 1ns / 1ps

module lprf_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lprf_pkg::in_item_t in_data_i,
  output logic               q_valid_o,
  output lprf_pkg::entry_t   q_entry_o,
  input  logic               q_take_i
);
  import lprf_pkg::*;

  entry_t     fifo_q [2];
  logic [1:0] count_q, count_d;
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic       enq, deq;
  entry_t     cls;

  always_comb begin
    cls.record_length = in_data_i.record_length;
    cls.data_byte     = in_data_i.data_byte;
    cls.len_bad       = (in_data_i.record_length == 8'd0);
    case (in_data_i.action)
      ACT_START: cls.op = OP_START;
      ACT_WRITE: cls.op = OP_WRITE;
      ACT_POP:   cls.op = OP_POP;
      default:   cls.op = OP_ILLEGAL;
    endcase
  end

  assign in_stall_o = (count_q == 2'd2);
  assign enq        = in_valid_i && !in_stall_o;
  assign deq        = q_take_i && (count_q != 2'd0);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_entry_o  = fifo_q[rd_q];

  always_comb begin
    wr_d    = enq ? !wr_q : wr_q;
    rd_d    = deq ? !rd_q : rd_q;
    count_d = count_q;
    if (enq && !deq) begin
      count_d = count_q + 2'd1;
    end else if (deq && !enq) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      wr_q    <= wr_d;
      rd_q    <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      fifo_q[wr_q] <= cls;
    end
  end

endmodule

// ===== sv/lprf_back.sv =====
// Back end: ring buffer store, pointers and counters, result register.
// Depends on lprf_pkg; fed by lprf_front through its queue.
`timescale 1ns / 1ps

module lprf_back #(
  parameter int BUFFER_BYTES = lprf_pkg::DEFAULT_BUFFER_BYTES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  lprf_pkg::entry_t    q_entry_i,
  output logic                q_take_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lprf_pkg::out_item_t out_data_o
);
  import lprf_pkg::*;

  localparam int PTR_W  = $clog2(BUFFER_BYTES);
  localparam int CNT_W  = $clog2(BUFFER_BYTES + 1);
  localparam int HELD_W = $clog2(BUFFER_BYTES / 2 + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(BUFFER_BYTES - 1);

  function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

  logic [7:0] mem [BUFFER_BYTES];
  logic [7:0] rd0_q, rd1_q;

  back_state_e state_q, state_d;
  logic [PTR_W-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [HELD_W-1:0] held_q, held_d;
  logic [CNT_W-1:0]  free_q, free_d;
  logic [7:0]        wrem_q, wrem_d, rrem_q, rrem_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic              out_free;
  logic              pop_begin;
  logic              pop_none;
  logic [PTR_W-1:0]  rp_n1, rp_n2;
  logic [31:0]       need_w, held_w, free_w;
  logic              mem_we;
  logic [PTR_W-1:0]  mem_waddr;
  logic [7:0]        mem_wdata;
  logic              rd_en;
  status_e           st;
  logic [7:0]        rbyte;
  logic              last;
  logic              load;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign pop_begin = (rrem_q == 8'd0);
  assign pop_none  = pop_begin && (held_q == '0);
  assign rp_n1     = adv(rp_q);
  assign rp_n2     = adv(rp_n1);
  assign need_w    = 32'(q_entry_i.record_length) + 32'd1;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i && q_entry_i.op == OP_POP && !pop_none) begin
          state_d = BK_POP;
        end
      end
      BK_POP: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Datapath and handshake
  always_comb begin
    q_take_o  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = wp_q;
    mem_wdata = q_entry_i.data_byte;
    rd_en     = 1'b0;
    load      = 1'b0;
    st        = ST_OK;
    rbyte     = 8'd0;
    last      = 1'b0;
    wp_d      = wp_q;
    rp_d      = rp_q;
    held_d    = held_q;
    free_d    = free_q;
    wrem_d    = wrem_q;
    rrem_d    = rrem_q;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          if (q_entry_i.op == OP_POP && !pop_none) begin
            // issue the store reads, finish in the pop state
            q_take_o = 1'b1;
            rd_en    = 1'b1;
          end else if (out_free) begin
            q_take_o = 1'b1;
            load     = 1'b1;
            case (q_entry_i.op)
              OP_START: begin
                if (wrem_q != 8'd0) begin
                  st = ST_SEQ;
                end else if (q_entry_i.len_bad) begin
                  st = ST_BAD_LEN;
                end else if (need_w > 32'(free_q)) begin
                  st = ST_NO_ROOM;
                end else begin
                  mem_we    = 1'b1;
                  mem_wdata = q_entry_i.record_length;
                  wp_d      = adv(wp_q);
                  free_d    = free_q - need_w[CNT_W-1:0];
                  wrem_d    = q_entry_i.record_length;
                end
              end
              OP_WRITE: begin
                if (wrem_q == 8'd0) begin
                  st = ST_SEQ;
                end else begin
                  mem_we = 1'b1;
                  wp_d   = adv(wp_q);
                  wrem_d = wrem_q - 8'd1;
                  if (wrem_q == 8'd1) begin
                    held_d = held_q + HELD_W'(1);
                  end
                end
              end
              OP_POP:  st = ST_EMPTY;
              default: st = ST_SEQ;
            endcase
          end
        end
      end
      BK_POP: begin
        if (out_free) begin
          load = 1'b1;
          if (pop_begin) begin
            // header and first data byte come in the same step
            rbyte  = rd1_q;
            rp_d   = rp_n2;
            held_d = held_q - HELD_W'(1);
            free_d = free_q + CNT_W'(2);
            rrem_d = (rd0_q == 8'd0) ? 8'd0 : rd0_q - 8'd1;
          end else begin
            rbyte  = rd0_q;
            rp_d   = rp_n1;
            free_d = free_q + CNT_W'(1);
            rrem_d = rrem_q - 8'd1;
          end
          last = (rrem_d == 8'd0);
        end
      end
      default: ;
    endcase
  end

  assign held_w = 32'(held_d);
  assign free_w = 32'(free_d);

  always_comb begin
    out_d.status       = st;
    out_d.read_byte    = rbyte;
    out_d.last_byte    = last;
    out_d.records_held = held_w[HELD_BITS-1:0];
    out_d.free_bytes   = free_w[FREE_BITS-1:0];
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      held_q      <= '0;
      free_q      <= CNT_W'(BUFFER_BYTES);
      wrem_q      <= 8'd0;
      rrem_q      <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      held_q      <= held_d;
      free_q      <= free_d;
      wrem_q      <= wrem_d;
      rrem_q      <= rrem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  // Byte store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd0_q <= mem[rp_q];
      rd1_q <= mem[rp_n1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
